FILE: hdl/usv_pkg.sv
// Package: shared types and constants for the UTF-8 stream validator.
`default_nettype none

package usv_pkg;

    // Width of the internal byte counter; reports saturate it to 32 bits
    localparam int OFFSET_WIDTH = 32;
    localparam int REPORT_OFFSET_WIDTH = 32;

    // Work queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam logic REG_MODE = 1'b0;   // word index of the mode register

    // Operating modes
    localparam logic [1:0] MODE_VALIDATE = 2'd0;
    localparam logic [1:0] MODE_INLINE = 2'd1;
    localparam logic [1:0] MODE_SANITISE = 2'd2;

    // Error report codes
    typedef enum logic [2:0] {
        ERR_INVALID = 3'd0,
        ERR_STRAY_CONT = 3'd1,
        ERR_CUT_ASCII = 3'd2,
        ERR_CUT_LEAD = 3'd3,
        ERR_FORBIDDEN = 3'd4,
        ERR_OVERLONG = 3'd5,
        ERR_TRUNCATED = 3'd6
    } err_code_t;

    // Byte classes; a lead's value is its sequence length
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_CONT = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_LEAD5 = 3'd5,
        CLS_LEAD6 = 3'd6,
        CLS_INVALID = 3'd7
    } byte_cls_t;

    // Input commands
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END = 1'b1;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } feed_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic [31:0] error_offset;
        logic        last;
    } result_t;

    // One accepted word's worth of work for the back end
    typedef struct packed {
        logic                           has_report;
        err_code_t                      code;
        logic [REPORT_OFFSET_WIDTH-1:0] offset;
        logic                           repl;      // emit EF BF BD after the report
        logic [2:0]                     char_len;  // 0 when no character is emitted
        logic [20:0]                    cp;
    } job_t;

    // Queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

FILE: hdl/usv_front.sv
// Front end: decodes each word, tracks the open sequence and builds a job.
`default_nettype none

module usv_front
    import usv_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire [1:0]  mode,
    input  wire        feed_valid,
    input  wire feed_t feed,
    input  wire        q_full,
    output logic       feed_stall,
    output logic       push,
    output job_t       job
);

    localparam int CMP_WIDTH = (OFFSET_WIDTH > REPORT_OFFSET_WIDTH) ?
        OFFSET_WIDTH : REPORT_OFFSET_WIDTH;

    function automatic byte_cls_t byte_class(input logic [7:0] b);
        byte_cls_t c;
        case (b) inside
            [8'h00:8'h7F]: c = CLS_ASCII;
            [8'h80:8'hBF]: c = CLS_CONT;
            [8'hC0:8'hDF]: c = CLS_LEAD2;
            [8'hE0:8'hEF]: c = CLS_LEAD3;
            [8'hF0:8'hF7]: c = CLS_LEAD4;
            [8'hF8:8'hFB]: c = CLS_LEAD5;
            [8'hFC:8'hFD]: c = CLS_LEAD6;
            default:       c = CLS_INVALID;
        endcase
        return c;
    endfunction

    function automatic logic [30:0] lead_payload(input logic [7:0] b, input byte_cls_t c);
        logic [30:0] p;
        case (c)
            CLS_LEAD2: p = {20'd0, b[4:0], 6'd0};
            CLS_LEAD3: p = {15'd0, b[3:0], 12'd0};
            CLS_LEAD4: p = {10'd0, b[2:0], 18'd0};
            CLS_LEAD5: p = {5'd0, b[1:0], 24'd0};
            default:   p = {b[0], 30'd0};
        endcase
        return p;
    endfunction

    function automatic logic [30:0] overlong_min(input logic [2:0] slc);
        logic [30:0] m;
        case (slc)
            3'd1:    m = 31'h80;
            3'd2:    m = 31'h800;
            3'd3:    m = 31'h10000;
            3'd4:    m = 31'h200000;
            3'd5:    m = 31'h4000000;
            default: m = 31'h0;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] enc_len(input logic [20:0] c);
        logic [2:0] n;
        if (c < 21'h80) n = 3'd1;
        else if (c < 21'h800) n = 3'd2;
        else if (c < 21'h10000) n = 3'd3;
        else n = 3'd4;
        return n;
    endfunction

    logic [2:0]              needed_reg, needed_next;
    logic [2:0]              slc_reg, slc_next;
    logic [30:0]             pcp_reg, pcp_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;

    logic        take;
    byte_cls_t   cls;
    logic [2:0]  needed_dec;
    logic [30:0] cont_bits;
    logic [30:0] acc;
    logic        forbidden;
    logic        has_report;
    err_code_t   code;
    logic        emit_char;
    logic [20:0] char_val;
    logic        bump;
    logic [REPORT_OFFSET_WIDTH-1:0] rep_offset;

    assign feed_stall = q_full;
    assign take = feed_valid && !q_full;
    assign cls = byte_class(feed.in_byte);
    assign needed_dec = needed_reg - 3'd1;

    // Place the continuation payload by the bytes still expected after it
    always_comb
    begin
        case (needed_dec)
            3'd0:    cont_bits = {25'd0, feed.in_byte[5:0]};
            3'd1:    cont_bits = {19'd0, feed.in_byte[5:0], 6'd0};
            3'd2:    cont_bits = {13'd0, feed.in_byte[5:0], 12'd0};
            3'd3:    cont_bits = {7'd0, feed.in_byte[5:0], 18'd0};
            3'd4:    cont_bits = {1'd0, feed.in_byte[5:0], 24'd0};
            default: cont_bits = {feed.in_byte[0], 30'd0};
        endcase
    end

    assign acc = pcp_reg | cont_bits;
    assign forbidden = (acc > 31'h10FFFF) || ((acc >= 31'hFDD0) && (acc <= 31'hFDEF)) ||
        (acc[15:1] == 15'h7FFF) || (acc[30:11] == 20'h1B);

    // Clamp the running offset for reports
    assign rep_offset = (CMP_WIDTH'(offset_reg) > CMP_WIDTH'({REPORT_OFFSET_WIDTH{1'b1}})) ?
        {REPORT_OFFSET_WIDTH{1'b1}} : REPORT_OFFSET_WIDTH'(offset_reg);

    // Decode the word against the open sequence
    always_comb
    begin
        needed_next = needed_reg;
        slc_next = slc_reg;
        pcp_next = pcp_reg;
        has_report = 1'b0;
        code = ERR_INVALID;
        emit_char = 1'b0;
        char_val = 21'd0;
        bump = 1'b0;
        if (feed.command == CMD_END)
        begin
            if (needed_reg != 3'd0)
            begin
                has_report = 1'b1;
                code = ERR_TRUNCATED;
                needed_next = 3'd0;
                bump = 1'b1;
            end
        end
        else
        begin
            bump = 1'b1;
            if (cls == CLS_INVALID)
            begin
                has_report = 1'b1;
                code = ERR_INVALID;
                needed_next = 3'd0;
            end
            else if (needed_reg == 3'd0)
            begin
                if (cls == CLS_CONT)
                begin
                    has_report = 1'b1;
                    code = ERR_STRAY_CONT;
                end
                else if (cls == CLS_ASCII)
                begin
                    pcp_next = {23'd0, feed.in_byte};
                    emit_char = 1'b1;
                    char_val = {13'd0, feed.in_byte};
                end
                else
                begin
                    needed_next = cls - 3'd1;
                    slc_next = cls - 3'd1;
                    pcp_next = lead_payload(feed.in_byte, cls);
                end
            end
            else if (cls == CLS_ASCII)
            begin
                has_report = 1'b1;
                code = ERR_CUT_ASCII;
                needed_next = 3'd0;
                pcp_next = {23'd0, feed.in_byte};
                emit_char = 1'b1;
                char_val = {13'd0, feed.in_byte};
            end
            else if (cls != CLS_CONT)
            begin
                has_report = 1'b1;
                code = ERR_CUT_LEAD;
                needed_next = cls - 3'd1;
                slc_next = cls - 3'd1;
                pcp_next = lead_payload(feed.in_byte, cls);
            end
            else
            begin
                needed_next = needed_dec;
                pcp_next = acc;
                if (needed_dec == 3'd0)
                begin
                    if (forbidden)
                    begin
                        has_report = 1'b1;
                        code = ERR_FORBIDDEN;
                    end
                    else if (acc < overlong_min(slc_reg))
                    begin
                        has_report = 1'b1;
                        code = ERR_OVERLONG;
                    end
                    else
                    begin
                        emit_char = 1'b1;
                        char_val = acc[20:0];
                    end
                end
            end
        end
    end

    // Build the job for the back end
    always_comb
    begin
        job.has_report = has_report;
        job.code = code;
        job.offset = rep_offset;
        job.repl = has_report && (mode == MODE_SANITISE);
        job.char_len = (emit_char && (mode != MODE_VALIDATE)) ? enc_len(char_val) : 3'd0;
        job.cp = char_val;
    end

    assign push = take && (job.has_report || (job.char_len != 3'd0));

    // Advance the offset, saturating
    always_comb
    begin
        offset_next = offset_reg;
        if (bump && (offset_reg != {OFFSET_WIDTH{1'b1}}))
        begin
            offset_next = offset_reg + OFFSET_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= 3'd0;
            slc_reg <= 3'd0;
            pcp_reg <= 31'd0;
            offset_reg <= '0;
        end
        else if (take)
        begin
            needed_reg <= needed_next;
            slc_reg <= slc_next;
            pcp_reg <= pcp_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/usv_queue.sv
// Job queue: short register FIFO between the front and back end.
`default_nettype none

module usv_queue
    import usv_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  wire job_t  push_job,
    input  wire        pop,
    output job_t       head,
    output q_status_t  status
);

    job_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_WIDTH:0]   count_reg, count_next;

    assign head = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full = (count_reg == (QPTR_WIDTH + 1)'(QUEUE_DEPTH));

    // Move the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_WIDTH'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_WIDTH'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_WIDTH + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_WIDTH + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

FILE: hdl/usv_back.sv
// Back end: expands each job into result words, one per cycle while not stalled.
`default_nettype none

module usv_back
    import usv_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire job_t  head,
    input  wire q_status_t status,
    output logic       pop,
    output logic       result_valid,
    input  wire        result_stall,
    output result_t    result
);

    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [2:0] len,
                                             input logic [2:0] idx);
        logic [7:0] b;
        case (len)
            3'd1: b = {1'b0, c[6:0]};
            3'd2: b = (idx == 3'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
            3'd3:
            begin
                case (idx)
                    3'd0:    b = {4'b1110, c[15:12]};
                    3'd1:    b = {2'b10, c[11:6]};
                    default: b = {2'b10, c[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0:    b = {5'b11110, c[20:18]};
                    3'd1:    b = {2'b10, c[17:12]};
                    3'd2:    b = {2'b10, c[11:6]};
                    default: b = {2'b10, c[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    result_t    result_reg;

    logic       head_valid;
    logic       load;
    logic [3:0] total;
    logic       job_done;
    logic [2:0] rel;
    logic [2:0] char_idx;
    result_t    item;

    assign head_valid = !status.empty;
    assign load = head_valid && (!valid_reg || !result_stall);
    assign total = {3'd0, head.has_report} + (head.repl ? 4'd3 : 4'd0) + {1'b0, head.char_len};
    assign job_done = ({1'b0, step_reg} == (total - 4'd1));
    assign pop = load && job_done;
    assign rel = step_reg - {2'd0, head.has_report};
    assign char_idx = rel - (head.repl ? 3'd3 : 3'd0);

    // Select the word for the current step: report, replacement, then character
    always_comb
    begin
        item.kind = KIND_BYTE;
        item.out_byte = 8'd0;
        item.error_code = 3'd0;
        item.error_offset = 32'd0;
        item.last = job_done;
        if (head.has_report && (step_reg == 3'd0))
        begin
            item.kind = KIND_REPORT;
            item.error_code = head.code;
            item.error_offset = head.offset;
        end
        else if (head.repl && (rel < 3'd3))
        begin
            case (rel)
                3'd0:    item.out_byte = REPL_BYTE0;
                3'd1:    item.out_byte = REPL_BYTE1;
                default: item.out_byte = REPL_BYTE2;
            endcase
        end
        else
        begin
            item.out_byte = utf8_byte(head.cp, head.char_len, char_idx);
        end
    end

    // Advance through the job and hold the output word under stall
    always_comb
    begin
        step_next = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next = job_done ? 3'd0 : step_reg + 3'd1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= item;
        end
    end

    assign result_valid = valid_reg;
    assign result = result_reg;

    a_step_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, step_reg} < total))
        else $error("step beyond the job's word count");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (total != 4'd0) && (total <= 4'd5))
        else $error("queued job with no results or too many");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (step_reg == 3'd0))
        else $error("step left mid-job with the queue empty");

endmodule

`default_nettype wire

FILE: hdl/utf8_stream_validator.sv
// Top level: UTF-8 stream validator with mode register and decoupled back end.
//
//  channel  | direction | handshake                     | word
//  ---------+-----------+-------------------------------+------------------------
//  feed     | in        | feed_valid / feed_stall       | feed_t: command, in_byte
//  result   | out       | result_valid / result_stall   | result_t: report or byte
//  config   | in        | APB psel/penable/pwrite/pready| mode at address 0
//
// The front end takes one word per cycle while the 4-entry job queue has room.
// The back end drains one result word per cycle when not stalled; a word that yields k
// results holds it till all are out, so the queue absorbs bursts of multi-byte output.
// With the back end idle, an accepted word is written into the job queue and its first
// result is then registered from the queue head into the back end's output word.
// Reset clears the decoder state, the byte offset, the mode, the queue and output valid.
// A stalled result holds its word; feed_stall rises only when the queue is full.
`default_nettype none

module utf8_stream_validator
    import usv_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [PADDR_WIDTH-1:0]  paddr,
    input  wire [PDATA_WIDTH-1:0]  pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready,
    input  wire                    feed_valid,
    output logic                   feed_stall,
    input  wire feed_t             feed,
    output logic                   result_valid,
    input  wire                    result_stall,
    output result_t                result
);

    logic [1:0] mode_reg, mode_next;
    logic       cfg_write;
    logic       push;
    logic       pop;
    job_t       job;
    job_t       head;
    q_status_t  status;

    // Decode the mode register write
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_WIDTH-1] == REG_MODE);

    always_comb
    begin
        mode_next = cfg_write ? pwdata[1:0] : mode_reg;
    end

    always_comb
    begin
        prdata = (paddr[PADDR_WIDTH-1] == REG_MODE) ?
            {{(PDATA_WIDTH - 2){1'b0}}, mode_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_VALIDATE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    usv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .feed_valid (feed_valid),
        .feed       (feed),
        .q_full     (status.full),
        .feed_stall (feed_stall),
        .push       (push),
        .job        (job)
    );

    usv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    usv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
